/* sv/ctw_pkg.sv */
`timescale 1ns / 1ps

package ctw_pkg;

    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 8;
    localparam int CELL_IDX_W = 11;
    localparam int DATA_W     = 16;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int HW_OUT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_PUT_CHAR     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACKSPACE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_POS      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LATCH_CURSOR = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ_CELL    = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_VT  = 8'h0B;

    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CELL = 2'd2;

    localparam logic [3:0] BACK_COLOR_RESET = 4'd0;
    localparam logic [3:0] FORE_COLOR_RESET = 4'd15;
    localparam logic [DATA_W-1:0] BLANK_CELL_RESET = 16'd0;

    typedef struct packed {
        logic [3:0]        back_color;
        logic [3:0]        fore_color;
        logic [DATA_W-1:0] blank_cell;
    } cfg_t;

endpackage

/* sv/ctw_mem.sv */
`timescale 1ns / 1ps

module ctw_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ctw_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [ctw_pkg::DATA_W-1:0] rdata
);
    import ctw_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ctw_ctrl.sv */
`timescale 1ns / 1ps

module ctw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctw_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctw_pkg::REQ_W-1:0]      req_type,
    input  logic [ctw_pkg::CHAR_W-1:0]     char_code,
    input  logic                           advance,
    input  logic [ctw_pkg::POS_W-1:0]      pos_x,
    input  logic [ctw_pkg::POS_W-1:0]      pos_y,
    input  logic [ctw_pkg::CELL_IDX_W-1:0] cell_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ctw_pkg::DATA_W-1:0]     read_data,
    output logic [ctw_pkg::COL_OUT_W-1:0]  cursor_col,
    output logic [ctw_pkg::ROW_OUT_W-1:0]  cursor_row,
    output logic [ctw_pkg::HW_OUT_W-1:0]   hw_cursor_index,
    output logic                           mem_we,
    output logic [AW-1:0]                  mem_waddr,
    output logic [ctw_pkg::DATA_W-1:0]     mem_wdata,
    output logic [AW-1:0]                  mem_raddr,
    input  logic [ctw_pkg::DATA_W-1:0]     mem_rdata
);
    import ctw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_HW  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_FILL,
        ST_RESP
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       cnt_reg;
    logic                init_done_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic [AW-1:0]       hw_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [HW_OUT_W-1:0] out_hw_reg;

    logic [REQ_W-1:0]      req_type_reg;
    logic [CHAR_W-1:0]     req_code_reg;
    logic                  req_adv_reg;
    logic [POS_W-1:0]      req_pos_x_reg;
    logic [POS_W-1:0]      req_pos_y_reg;
    logic [CELL_IDX_W-1:0] req_cell_reg;
    logic [DATA_W-1:0]     rd_hold_reg;

    logic [AW-1:0]     cur_idx;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_next;
    logic [AW-1:0]     hw_next;
    logic [DATA_W-1:0] rd_next;
    logic              exec_we;
    logic [AW-1:0]     exec_waddr;
    logic [DATA_W-1:0] exec_wdata;
    logic              line_feed;
    logic              go_scroll;
    logic              go_clear;
    logic              out_free;
    logic              out_load;
    logic              accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = out_free &&
                      ((state_reg == ST_EXEC && !go_clear && !go_scroll) ||
                       state_reg == ST_RESP);

    always_comb
    begin
        cur_idx    = AW'(AW'(row_reg) * ROW_STRIDE + AW'(col_reg));
        col_next   = col_reg;
        row_next   = row_reg;
        hw_next    = hw_reg;
        rd_next    = '0;
        exec_we    = 1'b0;
        exec_waddr = cur_idx;
        exec_wdata = {cfg.back_color, cfg.fore_color, req_code_reg};
        line_feed  = 1'b0;
        go_scroll  = 1'b0;
        go_clear   = 1'b0;
        unique case (req_type_reg)
            REQ_PUT_CHAR:
            begin
                if (req_code_reg == CHAR_LF)
                begin
                    line_feed = 1'b1;
                end
                else if (req_code_reg != CHAR_BS && req_code_reg != CHAR_TAB &&
                         req_code_reg != CHAR_VT)
                begin
                    exec_we = 1'b1;
                    if (req_adv_reg)
                    begin
                        if (col_reg == LAST_COL)
                        begin
                            line_feed = 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
            end
            REQ_BACKSPACE:
            begin
                exec_waddr = cur_idx - AW'(1);
                exec_wdata = cfg.blank_cell;
                exec_we    = (cur_idx != '0);
                if (col_reg != '0)
                begin
                    col_next = col_reg - CW'(1);
                end
            end
            REQ_CLEAR:
            begin
                go_clear = 1'b1;
                col_next = '0;
                row_next = '0;
                hw_next  = '0;
            end
            REQ_SET_POS:
            begin
                col_next = (req_pos_x_reg > POS_W'(COLUMNS - 1)) ?
                           LAST_COL : CW'(req_pos_x_reg);
                row_next = (req_pos_y_reg > POS_W'(ROWS - 1)) ?
                           LAST_ROW : RW'(req_pos_y_reg);
            end
            REQ_LATCH_CURSOR:
            begin
                hw_next = cur_idx;
            end
            REQ_READ_CELL:
            begin
                if (32'(req_cell_reg) < 32'(CELLS))
                begin
                    rd_next = mem_rdata;
                end
            end
            default:
            begin
            end
        endcase
        if (line_feed)
        begin
            col_next = '0;
            if (row_reg == LAST_ROW)
            begin
                go_scroll = 1'b1;
                hw_next   = SCROLL_HW;
            end
            else
            begin
                row_next = row_reg + RW'(1);
            end
        end
    end

    always_comb
    begin
        mem_raddr = (state_reg == ST_COPY) ? cnt_reg + ROW_STRIDE : AW'(cell_index);
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = mem_rdata;
        unique case (state_reg)
            ST_EXEC:
            begin
                mem_we    = exec_we;
                mem_waddr = exec_waddr;
                mem_wdata = exec_wdata;
            end
            ST_COPY:
            begin
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_reg - AW'(1);
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = init_done_reg ? cfg.blank_cell : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_type;
            req_code_reg  <= char_code;
            req_adv_reg   <= advance;
            req_pos_x_reg <= pos_x;
            req_pos_y_reg <= pos_y;
            req_cell_reg  <= cell_index;
        end
        if (state_reg == ST_EXEC)
        begin
            rd_hold_reg <= rd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            init_done_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_hw_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                    hw_reg  <= hw_next;
                    cnt_reg <= '0;
                    if (go_clear)
                    begin
                        state_reg <= ST_FILL;
                    end
                    else if (go_scroll)
                    begin
                        state_reg <= ST_COPY;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= rd_next;
                        out_col_reg   <= COL_OUT_W'(col_next);
                        out_row_reg   <= ROW_OUT_W'(row_next);
                        out_hw_reg    <= HW_OUT_W'(hw_next);
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_COPY:
                begin
                    if (cnt_reg == COPY_LAST)
                    begin
                        state_reg <= ST_FILL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                end
                ST_FILL:
                begin
                    if (cnt_reg == LAST_CELL)
                    begin
                        init_done_reg <= 1'b1;
                        state_reg     <= init_done_reg ? ST_RESP : ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= rd_hold_reg;
                        out_col_reg   <= COL_OUT_W'(col_reg);
                        out_row_reg   <= ROW_OUT_W'(row_reg);
                        out_hw_reg    <= HW_OUT_W'(hw_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_data_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign hw_cursor_index = out_hw_reg;

endmodule

/* sv/text_console_writer.sv */
`timescale 1ns / 1ps
// Text console writer: a COLUMNS x ROWS store of 16-bit cells (attribute byte
// over character byte) plus a text cursor and a latched hardware cursor.
// Request channel (in_valid/in_ready): req_type selects put char, backspace,
// clear, set position, latch cursor or read cell; one result per request.
// Result channel (out_valid/out_ready): read_data, cursor position after the
// request and the latched hardware cursor index.
// Timing: a request is accepted, issuing the cell read, then executed with the
// registered read data of the cell store, writing any cell it changes. Clear
// fills every cell with the blank cell; a scroll (line feed on the last row)
// copies rows up and blanks the last row, one cell copied or filled per cycle.
// The next request is accepted while a finished result waits; a stalled
// receiver holds the result, and further requests wait behind it.
// Reset: cursors clear, colors go to back 0 / fore 15, blank cell 0, and a
// clearing pass zeroes all COLUMNS*ROWS cells of the store (2000 at 80x25)
// with in_ready low. Configuration writes (cfg_write) take effect at once
// and are meant for idle periods.

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ctw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctw_pkg::REQ_W-1:0]      req_type,
    input  logic [ctw_pkg::CHAR_W-1:0]     char_code,
    input  logic                           advance,
    input  logic [ctw_pkg::POS_W-1:0]      pos_x,
    input  logic [ctw_pkg::POS_W-1:0]      pos_y,
    input  logic [ctw_pkg::CELL_IDX_W-1:0] cell_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ctw_pkg::DATA_W-1:0]     read_data,
    output logic [ctw_pkg::COL_OUT_W-1:0]  cursor_col,
    output logic [ctw_pkg::ROW_OUT_W-1:0]  cursor_row,
    output logic [ctw_pkg::HW_OUT_W-1:0]   hw_cursor_index
);
    import ctw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    cfg_t              cfg_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.back_color <= BACK_COLOR_RESET;
            cfg_reg.fore_color <= FORE_COLOR_RESET;
            cfg_reg.blank_cell <= BLANK_CELL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BACK_COLOR: cfg_reg.back_color <= cfg_data[3:0];
                CFG_FORE_COLOR: cfg_reg.fore_color <= cfg_data[3:0];
                CFG_BLANK_CELL: cfg_reg.blank_cell <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ctw_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ctw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .char_code       (char_code),
        .advance         (advance),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .hw_cursor_index (hw_cursor_index),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ctw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
    localparam int SCROLL_BUDGET = 50;
    localparam int RANDOM_ITEMS = 342;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [REQ_W-1:0]      kind;
        logic [CHAR_W-1:0]     code;
        logic                  adv;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [CELL_IDX_W-1:0] idx;
    } console_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic [HW_OUT_W-1:0]  hw;
    } console_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type = '0;
    logic [CHAR_W-1:0]     char_code = '0;
    logic                  advance = 1'b0;
    logic [POS_W-1:0]      pos_x = '0;
    logic [POS_W-1:0]      pos_y = '0;
    logic [CELL_IDX_W-1:0] cell_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic [COL_OUT_W-1:0]  cursor_col;
    logic [ROW_OUT_W-1:0]  cursor_row;
    logic [HW_OUT_W-1:0]   hw_cursor_index;

    // shadow of the console state
    logic [DATA_W-1:0]    shadow_cells [CELLS] = '{default: '0};
    logic [COL_OUT_W-1:0] cur_col = '0;
    logic [ROW_OUT_W-1:0] cur_row = '0;
    logic [HW_OUT_W-1:0]  hw_index = '0;
    logic [3:0]           back_nib = BACK_COLOR_RESET;
    logic [3:0]           fore_nib = FORE_COLOR_RESET;
    logic [DATA_W-1:0]    blank_val = BLANK_CELL_RESET;

    console_status_t status_queue [$];
    int scroll_count = 0;
    int error_count = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 56;

    text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void advance_line();
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                shadow_cells[i] = blank_val;
            cur_row = ROW_OUT_W'(ROWS - 1);
            hw_index = HW_OUT_W'(int'(cur_row) * COLUMNS);
            scroll_count++;
        end
    endfunction

    function automatic logic is_ignored_code(logic [CHAR_W-1:0] code);
        return code == CHAR_BS || code == CHAR_TAB || code == CHAR_VT;
    endfunction

    function automatic console_status_t apply_request(console_req_t r);
        console_status_t s;
        int here;
        logic [DATA_W-1:0] rd;
        rd = '0;
        here = int'(cur_col) + int'(cur_row) * COLUMNS;
        case (r.kind)
            REQ_PUT_CHAR:
            begin
                if (r.code == CHAR_LF)
                    advance_line();
                else if (!is_ignored_code(r.code))
                begin
                    shadow_cells[here] = {back_nib, fore_nib, r.code};
                    if (r.adv)
                    begin
                        cur_col = cur_col + 1'b1;
                        if (cur_col >= COLUMNS)
                            advance_line();
                    end
                end
            end
            REQ_BACKSPACE:
            begin
                if (here > 0)
                    shadow_cells[here - 1] = blank_val;
                if (cur_col != 0)
                    cur_col = cur_col - 1'b1;
            end
            REQ_CLEAR:
            begin
                foreach (shadow_cells[i])
                    shadow_cells[i] = blank_val;
                cur_col = '0;
                cur_row = '0;
                hw_index = '0;
            end
            REQ_SET_POS:
            begin
                cur_col = COL_OUT_W'((int'(r.x) > COLUMNS - 1) ? COLUMNS - 1 : int'(r.x));
                cur_row = ROW_OUT_W'((int'(r.y) > ROWS - 1) ? ROWS - 1 : int'(r.y));
            end
            REQ_LATCH_CURSOR:
                hw_index = HW_OUT_W'(here);
            REQ_READ_CELL:
            begin
                if (int'(r.idx) < CELLS)
                    rd = shadow_cells[r.idx];
            end
            default: ;
        endcase
        s.data = rd;
        s.col = cur_col;
        s.row = cur_row;
        s.hw = hw_index;
        return s;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want_v,
                                   input logic [DATA_W-1:0] got_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        console_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result transfer with nothing outstanding, expected none, actual %h %0d %0d %0d",
                             $time, read_data, cursor_col, cursor_row, hw_cursor_index);
            end
            else
            begin
                want = status_queue.pop_front();
                if (read_data !== want.data)
                    report_mismatch("read_data", want.data, read_data);
                if (cursor_col !== want.col)
                    report_mismatch("cursor_col", DATA_W'(want.col), DATA_W'(cursor_col));
                if (cursor_row !== want.row)
                    report_mismatch("cursor_row", DATA_W'(want.row), DATA_W'(cursor_row));
                if (hw_cursor_index !== want.hw)
                    report_mismatch("hw_cursor_index", DATA_W'(want.hw),
                                    DATA_W'(hw_cursor_index));
            end
        end
    end

    task automatic send_request(input console_req_t r);
        status_queue.push_back(apply_request(r));
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.kind;
        char_code <= r.code;
        advance <= r.adv;
        pos_x <= r.x;
        pos_y <= r.y;
        cell_index <= r.idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_colors(input logic [CFG_DATA_W-1:0] back_data,
                               input logic [CFG_DATA_W-1:0] fore_data,
                               input logic [CFG_DATA_W-1:0] blank_data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_BACK_COLOR;
        cfg_data <= back_data;
        @(posedge clk);
        cfg_index <= CFG_FORE_COLOR;
        cfg_data <= fore_data;
        @(posedge clk);
        cfg_index <= CFG_BLANK_CELL;
        cfg_data <= blank_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        back_nib = back_data[3:0];
        fore_nib = fore_data[3:0];
        blank_val = blank_data;
    endtask

    function automatic console_req_t make_req(logic [REQ_W-1:0] kind, int code, int adv,
                                              int x, int y, int idx);
        console_req_t r;
        r.kind = kind;
        r.code = CHAR_W'(code);
        r.adv = adv[0];
        r.x = POS_W'(x);
        r.y = POS_W'(y);
        r.idx = CELL_IDX_W'(idx);
        return r;
    endfunction

    function automatic console_req_t random_request();
        console_req_t r;
        int pick;
        int sel;
        int here;
        r.code = CHAR_W'($urandom);
        r.adv = 1'($urandom);
        r.x = POS_W'($urandom);
        r.y = POS_W'($urandom);
        r.idx = CELL_IDX_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.kind = REQ_PUT_CHAR;
            sel = $urandom_range(0, 19);
            if (sel < 12)
                r.code = CHAR_W'($urandom_range(8'h20, 8'h7E));
            else if (sel < 17)
                r.code = CHAR_W'($urandom_range(0, 255));
            else if (sel < 19)
                r.code = CHAR_LF;
            else
            begin
                case ($urandom_range(0, 2))
                    0: r.code = CHAR_BS;
                    1: r.code = CHAR_TAB;
                    default: r.code = CHAR_VT;
                endcase
            end
            r.adv = ($urandom_range(0, 9) != 0);
        end
        else if (pick < 65)
            r.kind = REQ_BACKSPACE;
        else if (pick < 66)
            r.kind = REQ_CLEAR;
        else if (pick < 74)
        begin
            r.kind = REQ_SET_POS;
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                r.x = POS_W'($urandom_range(COLUMNS - 20, COLUMNS - 1));
                r.y = POS_W'(ROWS - 1);
            end
            else if (sel >= 5)
            begin
                r.x = POS_W'($urandom_range(0, COLUMNS - 1));
                r.y = POS_W'($urandom_range(0, ROWS - 1));
            end
        end
        else if (pick < 79)
            r.kind = REQ_LATCH_CURSOR;
        else if (pick < 97)
        begin
            r.kind = REQ_READ_CELL;
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                here = int'(cur_col) + int'(cur_row) * COLUMNS - int'($urandom_range(0, 5));
                r.idx = (here < 0) ? '0 : CELL_IDX_W'(here);
            end
            else if (sel < 9)
                r.idx = CELL_IDX_W'($urandom_range(0, CELLS - 1));
        end
        else
            r.kind = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;

        // keep the number of full-store scrolls bounded
        if (r.kind == REQ_PUT_CHAR && scroll_count >= SCROLL_BUDGET && cur_row == ROWS - 1 &&
            (r.code == CHAR_LF || (r.adv && cur_col == COLUMNS - 1 && !is_ignored_code(r.code))))
        begin
            r.kind = REQ_SET_POS;
            r.y = POS_W'($urandom_range(0, ROWS - 2));
        end
        return r;
    endfunction

    task automatic test_reset_state();
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, CELLS));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, 2047));
        send_request(make_req(REQ_PUT_CHAR, 8'h41, 1, 0, 0, 0));
    endtask

    task automatic test_put_char();
        load_colors(16'hABCF, 16'h5430, 16'hFFFF);
        send_request(make_req(REQ_PUT_CHAR, 8'hFF, 1, 0, 0, 0));
        send_request(make_req(REQ_PUT_CHAR, 8'h00, 0, 0, 0, 0));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, 1));
    endtask

    task automatic test_control_codes();
        send_request(make_req(REQ_PUT_CHAR, CHAR_BS, 1, 0, 0, 0));
        send_request(make_req(REQ_PUT_CHAR, CHAR_TAB, 1, 0, 0, 0));
        send_request(make_req(REQ_PUT_CHAR, CHAR_VT, 1, 0, 0, 0));
        send_request(make_req(REQ_PUT_CHAR, CHAR_LF, 1, 0, 0, 0));
    endtask

    task automatic test_wrap_scroll();
        send_request(make_req(REQ_SET_POS, 0, 0, 255, 255, 0));
        send_request(make_req(REQ_PUT_CHAR, 8'h5A, 1, 0, 0, 0));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, CELLS - COLUMNS - 1));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, CELLS - 1));
    endtask

    task automatic test_backspace();
        // column 0 on the last row: the cell above-right gets blanked
        send_request(make_req(REQ_BACKSPACE, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, CELLS - COLUMNS - 1));
        send_request(make_req(REQ_SET_POS, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_BACKSPACE, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_READ_CELL, 0, 0, 0, 0, 0));
    endtask

    task automatic test_clear_latch();
        send_request(make_req(REQ_SET_POS, 0, 0, 37, 12, 0));
        send_request(make_req(REQ_LATCH_CURSOR, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_SPARE_6, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_SPARE_7, 0, 0, 0, 0, 0));
        send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
        console_req_t r;
        int counted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted = 0;
        while (counted < items)
        begin
            r = random_request();
            counted++;
            send_request(r);
            if ($urandom_range(0, 99) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_put_char();
        test_control_codes();
        test_wrap_scroll();
        test_backspace();
        test_clear_latch();
        load_colors(16'h1234, 16'h00A7, 16'h0720);
        test_random_traffic(RANDOM_ITEMS, 36, 56);
        load_colors(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        test_random_traffic(RANDOM_ITEMS, 56, 36);
        load_colors(16'hFFF0, 16'h000F, 16'h0000);
        test_random_traffic(RANDOM_ITEMS, 0, 0);
        repeat (CELLS + 16) @(posedge clk);
        if (error_count == 0 && status_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
